// ===== src/scpa_pkg.sv =====
package scpa_pkg;

   // Field widths of the request and response beats.
   localparam int CMD_W    = 2;
   localparam int SIZE_W   = 16;
   localparam int CLS_W    = 4;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 4;
   localparam int CFREE_W  = 9;
   localparam int EBYTES_W = 24;
   localparam int NBYTES_W = 32;
   localparam int CTR_W    = 32;

   // Block size of class c is MIN_CLASS_BYTES << c; class 15 needs 22 bits.
   localparam int MIN_CLASS_BYTES = 64;
   localparam int BYTES_W         = 22;

   localparam int DEF_CLASS_BLOCKS = 256;
   localparam int DEF_NUM_CLASSES  = 10;

   localparam logic [CMD_W-1:0] CMD_ALLOC = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_FREE  = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_CLEAR = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_NONE  = CMD_W'(3);

   localparam logic [STATUS_W-1:0] ST_NORMAL_OK   = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_EMERG_OK    = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_ZERO_SIZE   = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = STATUS_W'(3);
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = STATUS_W'(4);
   localparam logic [STATUS_W-1:0] ST_FREED_EMERG = STATUS_W'(5);
   localparam logic [STATUS_W-1:0] ST_FREED_NORM  = STATUS_W'(6);
   localparam logic [STATUS_W-1:0] ST_OVERFLOW    = STATUS_W'(7);
   localparam logic [STATUS_W-1:0] ST_CLEARED     = STATUS_W'(8);
   localparam logic [STATUS_W-1:0] ST_BAD_CLASS   = STATUS_W'(9);

   // One operation on the class stacks.
   typedef struct packed {
      logic              pop;
      logic              push;
      logic [CLS_W-1:0]  cls;
      logic [SLOT_W-1:0] slot;
   } stk_op_type;

endpackage

// ===== src/scpa_channels.sv =====
interface scpa_req_if import scpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [SIZE_W-1:0]   size;
   logic                normal_granted;
   logic                from_emergency;
   logic [CLS_W-1:0]    block_class;
   logic [SLOT_W-1:0]   block_slot;

   modport source (output valid, cmd, size, normal_granted, from_emergency, block_class,
                   block_slot, input ready);
   modport sink   (input valid, cmd, size, normal_granted, from_emergency, block_class,
                   block_slot, output ready);
endinterface

interface scpa_rsp_if import scpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CLS_W-1:0]    class_index;
   logic [SLOT_W-1:0]   granted_slot;
   logic [CFREE_W-1:0]  class_free_blocks;
   logic [EBYTES_W-1:0] emergency_bytes_in_use;
   logic [EBYTES_W-1:0] emergency_peak_bytes;
   logic [NBYTES_W-1:0] normal_bytes_in_use;
   logic [NBYTES_W-1:0] normal_peak_bytes;
   logic [CTR_W-1:0]    oom_triggers;
   logic [CTR_W-1:0]    oom_rescues;
   logic [CTR_W-1:0]    emergency_failures;

   modport source (output valid, status, class_index, granted_slot, class_free_blocks,
                   emergency_bytes_in_use, emergency_peak_bytes, normal_bytes_in_use,
                   normal_peak_bytes, oom_triggers, oom_rescues, emergency_failures,
                   input ready);
   modport sink   (input valid, status, class_index, granted_slot, class_free_blocks,
                   emergency_bytes_in_use, emergency_peak_bytes, normal_bytes_in_use,
                   normal_peak_bytes, oom_triggers, oom_rescues, emergency_failures,
                   output ready);
endinterface

interface scpa_csr_if ();
   logic valid;
   logic ready;
   logic reserve_only;

   modport source (output valid, reserve_only, input ready);
   modport sink   (input valid, reserve_only, output ready);
endinterface

// ===== src/scpa_stacks.sv =====
module scpa_stacks import scpa_pkg::*; #(
   parameter int CLASS_BLOCKS = DEF_CLASS_BLOCKS,
   parameter int NUM_CLASSES  = DEF_NUM_CLASSES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stk_op_type                           op,
   output logic [$clog2(CLASS_BLOCKS+1)-1:0]    count,
   output logic [SLOT_W-1:0]                    slot
);

   localparam int CNT_W  = $clog2(CLASS_BLOCKS + 1);
   localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int DEPTH  = NUM_CLASSES * CLASS_BLOCKS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [CNT_W-1:0]  count_ff [NUM_CLASSES];
   logic [CNT_W-1:0]  low_ff   [NUM_CLASSES];
   logic [SLOT_W-1:0] stack_mem_ff [DEPTH];
   logic [SLOT_W-1:0] rd_data_ff;
   logic [SLOT_W-1:0] dflt_ff;
   logic              use_mem_ff;

   logic [CIDX_W-1:0] sel;
   logic [CNT_W-1:0]  low;
   logic [CNT_W-1:0]  pos_rd;
   logic [ADDR_W-1:0] addr_rd;
   logic [ADDR_W-1:0] addr_wr;

   // Entries below the lowest fill level ever reached were never written, so
   // their own position is returned in place of the memory contents.
   always_comb begin
      sel     = op.cls[CIDX_W-1:0];
      count   = count_ff[sel];
      low     = low_ff[sel];
      pos_rd  = count - 1'b1;
      addr_rd = ADDR_W'(int'(sel) * CLASS_BLOCKS + int'(pos_rd));
      addr_wr = ADDR_W'(int'(sel) * CLASS_BLOCKS + int'(count));
      slot    = use_mem_ff ? rd_data_ff : dflt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            count_ff[c] <= CNT_W'(CLASS_BLOCKS);
            low_ff[c]   <= CNT_W'(CLASS_BLOCKS);
         end
      end else if (op.pop) begin
         count_ff[sel] <= pos_rd;
         if (pos_rd < low) begin
            low_ff[sel] <= pos_rd;
         end
      end else if (op.push) begin
         count_ff[sel] <= count + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (op.push) begin
         stack_mem_ff[addr_wr] <= op.slot;
      end
      if (op.pop) begin
         rd_data_ff <= stack_mem_ff[addr_rd];
         use_mem_ff <= (pos_rd >= low);
         dflt_ff    <= SLOT_W'(pos_rd);
      end
   end

endmodule

// ===== src/size_class_pool_allocator.sv =====
// Emergency pool allocator with power-of-two size classes. Each request beat is
// an allocate, a free or a statistics clear; every beat except the unused
// command code returns exactly one response beat, in order. A nonzero allocate is
// counted against the normal pool when emergency mode is off and the upstream
// allocator granted it; otherwise the size is mapped to the smallest class that
// fits (class c holds blocks of 64 << c bytes) and a block index is popped from
// that class's LIFO free stack. Frees of emergency blocks push the index back.
// The block takes one beat per clock cycle while the response side keeps up.
// A request taken into the input register is worked on straight out of it
// while the stack memory is read; when it moves on, the result, the
// statistics and the popped index are all registered together, and the
// response beat is offered from the response register. A stalled response
// holds the input register, and request ready drops once both registers
// are full and the response is stalled. The stack memory holds
// NUM_CLASSES * CLASS_BLOCKS entries; it needs no clearing pass after reset,
// because a per-class low-water mark tells which entries still hold their reset
// value, so requests are taken from the first cycle after reset. Emergency mode
// is written through the csr channel, which is always ready, and must only be
// changed while no request is in flight. All counters saturate.
module size_class_pool_allocator import scpa_pkg::*; #(
   parameter int CLASS_BLOCKS = DEF_CLASS_BLOCKS,
   parameter int NUM_CLASSES  = DEF_NUM_CLASSES
) (
   input  logic        clock,
   input  logic        reset,
   scpa_req_if.sink    req_ch,
   scpa_rsp_if.source  rsp_ch,
   scpa_csr_if.sink    csr_ch
);

   localparam int CNT_W = $clog2(CLASS_BLOCKS + 1);

   function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
      return BYTES_W'(MIN_CLASS_BYTES) << c;
   endfunction

   // Configuration.
   logic emerg_mode_ff;

   // Input register.
   logic                s0_valid_ff, s0_valid_in;
   logic [CMD_W-1:0]    s0_cmd_ff;
   logic [SIZE_W-1:0]   s0_size_ff;
   logic                s0_granted_ff;
   logic                s0_from_em_ff;
   logic [CLS_W-1:0]    s0_bcls_ff;
   logic [SLOT_W-1:0]   s0_bslot_ff;

   // Response register.
   logic                s1_valid_ff, s1_valid_in;
   logic [STATUS_W-1:0] s1_status_ff, s1_status_in;
   logic [CLS_W-1:0]    s1_cls_ff, s1_cls_in;
   logic                s1_pop_ff, s1_pop_in;
   logic [CFREE_W-1:0]  s1_cfree_ff, s1_cfree_in;

   // Statistics.
   logic [CTR_W-1:0]    oom_trig_ff, oom_trig_in;
   logic [CTR_W-1:0]    oom_resc_ff, oom_resc_in;
   logic [CTR_W-1:0]    emerg_fail_ff, emerg_fail_in;
   logic [EBYTES_W-1:0] emerg_bytes_ff, emerg_bytes_in;
   logic [EBYTES_W-1:0] emerg_peak_ff, emerg_peak_in;
   logic [NBYTES_W-1:0] normal_bytes_ff, normal_bytes_in;
   logic [NBYTES_W-1:0] normal_peak_ff, normal_peak_in;

   logic                s1_free;
   logic                adv;
   logic                take;
   logic                fit_found;
   logic [CLS_W-1:0]    fit_cls;
   logic                is_alloc;
   logic                cls_ok;
   logic                class_full;
   logic [BYTES_W-1:0]  cbytes;
   logic [NBYTES_W:0]   nsum;
   logic [EBYTES_W:0]   esum;
   stk_op_type          stk_op;
   logic [CNT_W-1:0]    stk_count;
   logic [SLOT_W-1:0]   stk_slot;

   scpa_stacks #(
      .CLASS_BLOCKS (CLASS_BLOCKS),
      .NUM_CLASSES  (NUM_CLASSES)
   ) u_stacks (
      .clock (clock),
      .reset (reset),
      .op    (stk_op),
      .count (stk_count),
      .slot  (stk_slot)
   );

   // Two-stage handshake: the input register refills in the same cycle that
   // its beat moves on, and the response register is parted from the input.
   assign s1_free       = !s1_valid_ff || rsp_ch.ready;
   assign adv           = s0_valid_ff && s1_free;
   assign req_ch.ready  = !s0_valid_ff || s1_free;
   assign take          = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (take) begin
         s0_valid_in = 1'b1;
      end else if (adv) begin
         s0_valid_in = 1'b0;
      end

      s1_valid_in = s1_valid_ff;
      if (adv) begin
         // The unused command code is consumed without a response.
         s1_valid_in = (s0_cmd_ff != CMD_NONE);
      end else if (rsp_ch.ready) begin
         s1_valid_in = 1'b0;
      end
   end

   // Smallest class whose block size covers the request.
   always_comb begin
      fit_found = 1'b0;
      fit_cls   = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (BYTES_W'(s0_size_ff) <= class_bytes(CLS_W'(c))) begin
            fit_found = 1'b1;
            fit_cls   = CLS_W'(c);
         end
      end
   end

   always_comb begin
      is_alloc   = (s0_cmd_ff == CMD_ALLOC);
      cls_ok     = (int'(s0_bcls_ff) < NUM_CLASSES) && (int'(s0_bslot_ff) < CLASS_BLOCKS);
      stk_op     = '0;
      stk_op.cls = is_alloc ? fit_cls : s0_bcls_ff;
      stk_op.slot = s0_bslot_ff;
      class_full = (stk_count == CNT_W'(CLASS_BLOCKS));
      cbytes     = class_bytes(stk_op.cls);
      nsum       = {1'b0, normal_bytes_ff} + (NBYTES_W + 1)'(s0_size_ff);
      esum       = {1'b0, emerg_bytes_ff} + (EBYTES_W + 1)'(cbytes);

      s1_status_in    = ST_NORMAL_OK;
      s1_cls_in       = '0;
      s1_pop_in       = 1'b0;
      s1_cfree_in     = '0;
      oom_trig_in     = oom_trig_ff;
      oom_resc_in     = oom_resc_ff;
      emerg_fail_in   = emerg_fail_ff;
      emerg_bytes_in  = emerg_bytes_ff;
      emerg_peak_in   = emerg_peak_ff;
      normal_bytes_in = normal_bytes_ff;
      normal_peak_in  = normal_peak_ff;

      case (s0_cmd_ff)
         CMD_ALLOC: begin
            if (s0_size_ff == '0) begin
               s1_status_in = ST_ZERO_SIZE;
            end else if (!emerg_mode_ff && s0_granted_ff) begin
               normal_bytes_in = nsum[NBYTES_W] ? '1 : nsum[NBYTES_W-1:0];
               if (normal_bytes_in > normal_peak_ff) begin
                  normal_peak_in = normal_bytes_in;
               end
               s1_status_in = ST_NORMAL_OK;
            end else begin
               // Normal pool refused or emergency mode on: fall back to the classes.
               if (!emerg_mode_ff) begin
                  oom_trig_in = sat_inc(oom_trig_ff);
               end
               if (!fit_found) begin
                  emerg_fail_in = sat_inc(emerg_fail_ff);
                  s1_status_in  = ST_TOO_LARGE;
               end else if (stk_count == '0) begin
                  emerg_fail_in = sat_inc(emerg_fail_ff);
                  s1_status_in  = ST_EXHAUSTED;
                  s1_cls_in     = fit_cls;
               end else begin
                  stk_op.pop     = adv;
                  emerg_bytes_in = esum[EBYTES_W] ? '1 : esum[EBYTES_W-1:0];
                  if (emerg_bytes_in > emerg_peak_ff) begin
                     emerg_peak_in = emerg_bytes_in;
                  end
                  if (emerg_mode_ff) begin
                     oom_resc_in = sat_inc(oom_resc_ff);
                  end
                  s1_status_in = ST_EMERG_OK;
                  s1_cls_in    = fit_cls;
                  s1_pop_in    = 1'b1;
                  s1_cfree_in  = CFREE_W'(stk_count - 1'b1);
               end
            end
         end
         CMD_FREE: begin
            if (!s0_from_em_ff) begin
               s1_status_in = ST_FREED_NORM;
            end else if (!cls_ok) begin
               s1_status_in = ST_BAD_CLASS;
            end else if (class_full) begin
               s1_status_in = ST_OVERFLOW;
               s1_cls_in    = s0_bcls_ff;
               s1_cfree_in  = CFREE_W'(stk_count);
            end else begin
               stk_op.push    = adv;
               emerg_bytes_in = (emerg_bytes_ff > EBYTES_W'(cbytes)) ?
                                emerg_bytes_ff - EBYTES_W'(cbytes) : '0;
               s1_status_in   = ST_FREED_EMERG;
               s1_cls_in      = s0_bcls_ff;
               s1_cfree_in    = CFREE_W'(stk_count + 1'b1);
            end
         end
         CMD_CLEAR: begin
            oom_trig_in    = '0;
            oom_resc_in    = '0;
            emerg_fail_in  = '0;
            normal_peak_in = normal_bytes_ff;
            emerg_peak_in  = emerg_bytes_ff;
            s1_status_in   = ST_CLEARED;
         end
         default: begin
            s1_status_in = ST_NORMAL_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emerg_mode_ff   <= 1'b0;
         s0_valid_ff     <= 1'b0;
         s1_valid_ff     <= 1'b0;
         oom_trig_ff     <= '0;
         oom_resc_ff     <= '0;
         emerg_fail_ff   <= '0;
         emerg_bytes_ff  <= '0;
         emerg_peak_ff   <= '0;
         normal_bytes_ff <= '0;
         normal_peak_ff  <= '0;
      end else begin
         if (csr_ch.valid) begin
            emerg_mode_ff <= csr_ch.reserve_only;
         end
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         // Statistics only move when a beat is processed, so the response
         // register and the statistics always describe the same beat.
         if (adv) begin
            oom_trig_ff     <= oom_trig_in;
            oom_resc_ff     <= oom_resc_in;
            emerg_fail_ff   <= emerg_fail_in;
            emerg_bytes_ff  <= emerg_bytes_in;
            emerg_peak_ff   <= emerg_peak_in;
            normal_bytes_ff <= normal_bytes_in;
            normal_peak_ff  <= normal_peak_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s0_cmd_ff     <= req_ch.cmd;
         s0_size_ff    <= req_ch.size;
         s0_granted_ff <= req_ch.normal_granted;
         s0_from_em_ff <= req_ch.from_emergency;
         s0_bcls_ff    <= req_ch.block_class;
         s0_bslot_ff   <= req_ch.block_slot;
      end
      if (adv) begin
         s1_status_ff <= s1_status_in;
         s1_cls_ff    <= s1_cls_in;
         s1_pop_ff    <= s1_pop_in;
         s1_cfree_ff  <= s1_cfree_in;
      end
   end

   // The popped index comes straight from the stack unit's read register,
   // which is loaded in the same cycle as the response register.
   assign rsp_ch.valid                  = s1_valid_ff;
   assign rsp_ch.status                 = s1_status_ff;
   assign rsp_ch.class_index            = s1_cls_ff;
   assign rsp_ch.granted_slot           = s1_pop_ff ? stk_slot : '0;
   assign rsp_ch.class_free_blocks      = s1_cfree_ff;
   assign rsp_ch.emergency_bytes_in_use = emerg_bytes_ff;
   assign rsp_ch.emergency_peak_bytes   = emerg_peak_ff;
   assign rsp_ch.normal_bytes_in_use    = normal_bytes_ff;
   assign rsp_ch.normal_peak_bytes      = normal_peak_ff;
   assign rsp_ch.oom_triggers           = oom_trig_ff;
   assign rsp_ch.oom_rescues            = oom_resc_ff;
   assign rsp_ch.emergency_failures     = emerg_fail_ff;

endmodule

// ===== src/scpa_checker.sv =====
module scpa_checker import scpa_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] status,
   input logic [CLS_W-1:0]    class_index,
   input logic [SLOT_W-1:0]   granted_slot,
   input logic [CFREE_W-1:0]  class_free_blocks,
   input logic [EBYTES_W-1:0] emergency_bytes_in_use,
   input logic [EBYTES_W-1:0] emergency_peak_bytes,
   input logic [NBYTES_W-1:0] normal_bytes_in_use,
   input logic [NBYTES_W-1:0] normal_peak_bytes,
   input logic [CTR_W-1:0]    oom_triggers,
   input logic [CTR_W-1:0]    oom_rescues,
   input logic [CTR_W-1:0]    emergency_failures
);

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && !rsp_ready)) |->
         (rsp_valid && $stable(status) && $stable(class_index) && $stable(granted_slot)
          && $stable(class_free_blocks)))
      else $error("response payload changed while stalled");

   // Peaks never fall below the current byte counts.
   a_peaks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (emergency_peak_bytes >= emergency_bytes_in_use &&
                     normal_peak_bytes >= normal_bytes_in_use))
      else $error("peak below current byte count");

   // A statistics clear leaves the counters at zero and the peaks at the byte counts.
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == ST_CLEARED) |->
         (oom_triggers == '0 && oom_rescues == '0 && emergency_failures == '0 &&
          emergency_peak_bytes == emergency_bytes_in_use &&
          normal_peak_bytes == normal_bytes_in_use))
      else $error("statistics not cleared");

   // An exhausted class reports no free blocks and a failure on record.
   a_exhausted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == ST_EXHAUSTED) |->
         (class_free_blocks == '0 && emergency_failures != '0))
      else $error("exhausted class reports free blocks");

   // A successful emergency allocation always holds some emergency bytes.
   a_emerg_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == ST_EMERG_OK) |-> (emergency_bytes_in_use != '0))
      else $error("emergency allocation without bytes in use");

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_ch.valid),
   .rsp_ready              (rsp_ch.ready),
   .status                 (rsp_ch.status),
   .class_index            (rsp_ch.class_index),
   .granted_slot           (rsp_ch.granted_slot),
   .class_free_blocks      (rsp_ch.class_free_blocks),
   .emergency_bytes_in_use (rsp_ch.emergency_bytes_in_use),
   .emergency_peak_bytes   (rsp_ch.emergency_peak_bytes),
   .normal_bytes_in_use    (rsp_ch.normal_bytes_in_use),
   .normal_peak_bytes      (rsp_ch.normal_peak_bytes),
   .oom_triggers           (rsp_ch.oom_triggers),
   .oom_rescues            (rsp_ch.oom_rescues),
   .emergency_failures     (rsp_ch.emergency_failures)
);
